// ----- hdl/ahp_pkg.sv -----
// types and constants shared by the announcement header parser
package ahp_pkg;

    localparam logic [31:0] HEADER_BYTES   = 32'd17;
    localparam logic [31:0] MAX_ID_SYMBOLS = 32'd32;
    localparam logic [31:0] POS_VERSION    = 32'd4;
    localparam logic [31:0] POS_PERIOD     = 32'd5;
    localparam logic [31:0] POS_IDLEN      = 32'd9;
    localparam logic [31:0] POS_KEYLEN     = 32'd13;
    localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;
    localparam logic [7:0]  VERSION_BYTE   = 8'h01;
    localparam logic [7:0]  MAGIC [4]      = '{8'h41, 8'h45, 8'h52, 8'h44};

    localparam int PADDR_W = 3;

    typedef enum logic [0:0] {
        REG_DELIVER_KEY  = 1'b0,
        REG_KEY_CAPACITY = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_SHORT   = 4'd1,
        ST_MAGIC   = 4'd2,
        ST_VERSION = 4'd3,
        ST_PERIOD  = 4'd4,
        ST_IDLEN   = 4'd5,
        ST_KEYLEN  = 4'd6,
        ST_TRUNC   = 4'd7,
        ST_TOOBIG  = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  key_byte;
        logic [3:0]  status;
        logic [30:0] period_seconds;
        logic [5:0]  id_length;
        logic [30:0] key_length;
        logic        run_end;
    } t_result;

    typedef struct packed {
        logic        deliver_key;
        logic [15:0] key_capacity;
    } t_cfg;

    typedef struct packed {
        logic    key_en;
        logic    verdict_en;
        t_result key_res;
        t_result verdict_res;
    } t_push;

endpackage

// ----- hdl/ahp_cfg.sv -----
// configuration registers behind the apb-style port
module ahp_cfg
    import ahp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_DELIVER_KEY:  n_cfg.deliver_key  = pwdata[0];
                REG_KEY_CAPACITY: n_cfg.key_capacity = pwdata[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deliver_key  <= 1'b1;
            r_cfg.key_capacity <= 16'd32;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_DELIVER_KEY:  prdata = {31'd0, r_cfg.deliver_key};
            REG_KEY_CAPACITY: prdata = {16'd0, r_cfg.key_capacity};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/ahp_parse.sv -----
// header state registers, field checks and result formation
module ahp_parse
    import ahp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_push o_push
);

    logic [31:0] r_pos, n_pos;
    logic [3:0]  r_fault, n_fault;
    logic [31:0] r_period, n_period;
    logic [31:0] r_idlen, n_idlen;
    logic [31:0] r_keylen, n_keylen;

    logic [3:0]  w_cand;
    logic [7:0]  w_b;
    logic [32:0] w_key_end;
    logic [32:0] w_key_end_n;
    logic        w_fits;
    logic        w_fits_n;
    logic        w_fwd;
    t_status     w_st;

    assign w_b = i_item.data_byte;

    always_comb begin
        n_period = r_period;
        n_idlen  = r_idlen;
        n_keylen = r_keylen;
        w_cand   = ST_OK;
        if (r_pos < POS_VERSION) begin
            if (w_b != MAGIC[r_pos[1:0]]) w_cand = ST_MAGIC;
        end else if (r_pos == POS_VERSION) begin
            if (w_b != VERSION_BYTE) w_cand = ST_VERSION;
        end else if (r_pos < POS_IDLEN) begin
            n_period = {r_period[23:0], w_b};
            if (r_pos == POS_IDLEN - 32'd1 && (n_period == 32'd0 || n_period[31]))
                w_cand = ST_PERIOD;
        end else if (r_pos < POS_KEYLEN) begin
            n_idlen = {r_idlen[23:0], w_b};
            if (r_pos == POS_KEYLEN - 32'd1 &&
                (n_idlen == 32'd0 || n_idlen[31] || n_idlen > MAX_ID_SYMBOLS))
                w_cand = ST_IDLEN;
        end else if (r_pos < HEADER_BYTES) begin
            n_keylen = {r_keylen[23:0], w_b};
            if (r_pos == HEADER_BYTES - 32'd1 && (n_keylen == 32'd0 || n_keylen[31]))
                w_cand = ST_KEYLEN;
        end
    end

    assign n_fault     = (r_fault == ST_OK) ? w_cand : r_fault;
    assign n_pos       = (r_pos == POS_MAX) ? r_pos : r_pos + 32'd1;
    assign w_key_end   = {1'b0, HEADER_BYTES} + {1'b0, r_keylen};
    assign w_key_end_n = {1'b0, HEADER_BYTES} + {1'b0, n_keylen};
    assign w_fits      = !i_cfg.deliver_key || {16'd0, i_cfg.key_capacity} >= r_keylen;
    assign w_fits_n    = !i_cfg.deliver_key || {16'd0, i_cfg.key_capacity} >= n_keylen;
    assign w_fwd       = (r_pos >= HEADER_BYTES) && (r_fault == ST_OK) &&
                         i_cfg.deliver_key && w_fits && ({1'b0, r_pos} < w_key_end);

    always_comb begin
        if (n_pos < HEADER_BYTES)             w_st = ST_SHORT;
        else if (n_fault != ST_OK)            w_st = t_status'(n_fault);
        else if ({1'b0, n_pos} < w_key_end_n) w_st = ST_TRUNC;
        else if (!w_fits_n)                   w_st = ST_TOOBIG;
        else                                  w_st = ST_OK;
    end

    always_comb begin
        o_push                 = '0;
        o_push.key_en          = i_fire & w_fwd;
        o_push.verdict_en      = i_fire & i_item.final_byte;
        o_push.key_res.key_byte = w_b;
        o_push.key_res.run_end  = !i_item.final_byte;
        o_push.verdict_res.is_verdict = 1'b1;
        o_push.verdict_res.status     = w_st;
        o_push.verdict_res.run_end    = 1'b1;
        if (w_st == ST_OK) begin
            o_push.verdict_res.period_seconds = n_period[30:0];
            o_push.verdict_res.id_length      = n_idlen[5:0];
            o_push.verdict_res.key_length     = n_keylen[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fault  <= ST_OK;
            r_period <= '0;
            r_idlen  <= '0;
            r_keylen <= '0;
        end else if (i_fire) begin
            if (i_item.final_byte) begin
                r_pos    <= '0;
                r_fault  <= ST_OK;
                r_period <= '0;
                r_idlen  <= '0;
                r_keylen <= '0;
            end else begin
                r_pos    <= n_pos;
                r_fault  <= n_fault;
                r_period <= n_period;
                r_idlen  <= n_idlen;
                r_keylen <= n_keylen;
            end
        end
    end

endmodule

// ----- hdl/ahp_out_queue.sv -----
// four-entry result queue that takes up to two results per cycle
module ahp_out_queue
    import ahp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result    r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] w_vaddr;
    logic       w_pop;
    logic [1:0] w_npush;

    assign o_valid  = (r_cnt != 3'd0);
    assign o_result = r_mem[r_rd];
    assign o_full   = (r_cnt > 3'd2);
    assign w_pop    = o_valid & !i_stall;
    assign w_npush  = {1'b0, i_push.key_en} + {1'b0, i_push.verdict_en};
    assign w_vaddr  = r_wr + {1'b0, i_push.key_en};
    assign n_wr     = r_wr + w_npush;
    assign n_rd     = r_rd + {1'b0, w_pop};
    assign n_cnt    = r_cnt + {1'b0, w_npush} - {2'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (i_push.key_en)     r_mem[r_wr]    <= i_push.key_res;
        if (i_push.verdict_en) r_mem[w_vaddr] <= i_push.verdict_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hdl/announcement_header_parser.sv -----
// top level of the announcement header parser
// Takes one message byte per transfer and returns key-byte and verdict results
// through a four-entry result queue. A byte is processed in the cycle it is
// accepted, so one byte per clock is sustained while the queue has room; a
// byte that ends a message inside the key can produce two results, and the
// input stalls while fewer than two queue entries are free. Configuration
// registers sit at byte address 0 (deliver_key) and 4 (key_capacity) and
// take effect on the next accepted byte.
module announcement_header_parser
    import ahp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg  w_cfg;
    t_push w_push;
    logic  w_full;
    logic  w_fire;

    assign o_stall = w_full;
    assign w_fire  = i_valid & !w_full;

    ahp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ahp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (i_item),
        .i_cfg   (w_cfg),
        .o_push  (w_push)
    );

    ahp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

// ----- tb/sv/ahp_scoreboard.sv -----
// scoreboard class: header parser prediction and result checking
`timescale 1ns / 1ps

package ahp_tb_pkg;
    import ahp_pkg::*;

    class ahp_scoreboard;
        logic [31:0] pos;
        t_status     fault;
        logic [31:0] period_sr;
        logic [31:0] idlen_sr;
        logic [31:0] keylen_sr;
        logic        deliver;
        logic [15:0] capacity;
        t_result     pending_results[$];
        int          errors;

        function new();
            clear_message();
            deliver  = 1'b1;
            capacity = 16'd32;
            errors   = 0;
        endfunction

        function void clear_message();
            pos       = '0;
            fault     = ST_OK;
            period_sr = '0;
            idlen_sr  = '0;
            keylen_sr = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            if (idx == REG_DELIVER_KEY) begin
                deliver = value[0];
            end else begin
                capacity = value[15:0];
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void latch_fault(t_status code);
            if (fault == ST_OK) begin
                fault = code;
            end
        endfunction

        function logic key_fits();
            return !deliver || ({16'd0, capacity} >= keylen_sr);
        endfunction

        function logic [63:0] key_end();
            return {32'd0, HEADER_BYTES} + {32'd0, keylen_sr};
        endfunction

        // works out the results of one accepted byte
        function void predict_byte(t_item it);
            logic [31:0] p;
            logic [7:0]  b;
            t_status     st;
            t_result     r;
            p = pos;
            b = it.data_byte;
            if (p < POS_VERSION) begin
                if (b != MAGIC[p[1:0]]) begin
                    latch_fault(ST_MAGIC);
                end
            end else if (p == POS_VERSION) begin
                if (b != VERSION_BYTE) begin
                    latch_fault(ST_VERSION);
                end
            end else if (p < POS_IDLEN) begin
                period_sr = {period_sr[23:0], b};
                if (p == POS_IDLEN - 1 && (period_sr == '0 || period_sr[31])) begin
                    latch_fault(ST_PERIOD);
                end
            end else if (p < POS_KEYLEN) begin
                idlen_sr = {idlen_sr[23:0], b};
                if (p == POS_KEYLEN - 1 && (idlen_sr == '0 || idlen_sr[31] ||
                                            idlen_sr > MAX_ID_SYMBOLS)) begin
                    latch_fault(ST_IDLEN);
                end
            end else if (p < HEADER_BYTES) begin
                keylen_sr = {keylen_sr[23:0], b};
                if (p == HEADER_BYTES - 1 && (keylen_sr == '0 || keylen_sr[31])) begin
                    latch_fault(ST_KEYLEN);
                end
            end else if (fault == ST_OK && deliver && key_fits() &&
                         {32'd0, p} < key_end()) begin
                r          = '0;
                r.key_byte = b;
                r.run_end  = !it.final_byte;
                pending_results.push_back(r);
            end
            if (pos != POS_MAX) begin
                pos = pos + 32'd1;
            end
            if (it.final_byte) begin
                if (pos < HEADER_BYTES) begin
                    st = ST_SHORT;
                end else if (fault != ST_OK) begin
                    st = fault;
                end else if ({32'd0, pos} < key_end()) begin
                    st = ST_TRUNC;
                end else if (!key_fits()) begin
                    st = ST_TOOBIG;
                end else begin
                    st = ST_OK;
                end
                r            = '0;
                r.is_verdict = 1'b1;
                r.status     = st;
                if (st == ST_OK) begin
                    r.period_seconds = period_sr[30:0];
                    r.id_length      = idlen_sr[5:0];
                    r.key_length     = keylen_sr[30:0];
                end
                r.run_end = 1'b1;
                pending_results.push_back(r);
                clear_message();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result 0x%0h arrived with nothing expected", got));
            end else begin
                want = pending_results.pop_front();
                compare_field("is_verdict", 32'(got.is_verdict), 32'(want.is_verdict));
                compare_field("key_byte", 32'(got.key_byte), 32'(want.key_byte));
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("period_seconds", 32'(got.period_seconds),
                              32'(want.period_seconds));
                compare_field("id_length", 32'(got.id_length), 32'(want.id_length));
                compare_field("key_length", 32'(got.key_length), 32'(want.key_length));
                compare_field("run_end", 32'(got.run_end), 32'(want.run_end));
            end
        endtask
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// top-level testbench for the announcement header parser
`timescale 1ns / 1ps

module tb_top;
    import ahp_pkg::*;
    import ahp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 50;

    typedef enum int {
        MSG_GOOD,
        MSG_TRUNC,
        MSG_LONG_KEY,
        MSG_MAGIC,
        MSG_VERSION,
        MSG_PERIOD,
        MSG_IDLEN,
        MSG_KEYLEN,
        MSG_SHORT,
        MSG_NOISE
    } t_msg_kind;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_item              i_item  = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_result            o_result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    ahp_scoreboard sb;
    int            send_pct = 0;
    int            recv_pct = 0;
    int            idle_cycles = 0;
    int            bytes_sent = 0;
    logic [7:0]    msg_q[$];

    announcement_header_parser u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // transfer monitor, receiver stalls and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.predict_byte(i_item);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_result);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    task automatic drive_byte(input t_item it);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message();
        t_item it;
        for (int i = 0; i < msg_q.size(); i++) begin
            it.data_byte  = msg_q[i];
            it.final_byte = (i == msg_q.size() - 1);
            drive_byte(it);
        end
    endtask

    task automatic push_word(input logic [31:0] w);
        msg_q.push_back(w[31:24]);
        msg_q.push_back(w[23:16]);
        msg_q.push_back(w[15:8]);
        msg_q.push_back(w[7:0]);
    endtask

    task automatic build_message(input t_msg_kind kind);
        logic [31:0] period;
        logic [31:0] idlen;
        logic [31:0] keylen;
        int          nkey;
        int          ntrail;
        int          cut;
        period = ($urandom_range(0, 3) == 0) ? 32'd1 : $urandom_range(1, 32'h7FFF_FFFF);
        idlen  = $urandom_range(1, MAX_ID_SYMBOLS);
        keylen = $urandom_range(1, 12);
        nkey   = keylen;
        ntrail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        case (kind)
            MSG_TRUNC: begin
                nkey   = $urandom_range(0, keylen - 1);
                ntrail = 0;
            end
            MSG_LONG_KEY: begin
                keylen = $urandom_range(0, 1) ? $urandom_range(13, 65535)
                                              : $urandom_range(32'h1_0000, 32'h7FFF_FFFF);
                nkey   = $urandom_range(0, 6);
                ntrail = 0;
            end
            MSG_PERIOD: begin
                period = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
                if ($urandom_range(0, 1)) begin
                    idlen = 32'd0;
                end
            end
            MSG_IDLEN: begin
                case ($urandom_range(0, 2))
                    0: idlen = 32'd0;
                    1: idlen = $urandom_range(MAX_ID_SYMBOLS + 1, 300);
                    default: idlen = $urandom | 32'h8000_0000;
                endcase
            end
            MSG_KEYLEN: begin
                keylen = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
                nkey   = $urandom_range(0, 4);
            end
            default: ;
        endcase
        msg_q.delete();
        for (int i = 0; i < 4; i++) begin
            msg_q.push_back(MAGIC[i]);
        end
        msg_q.push_back(VERSION_BYTE);
        push_word(period);
        push_word(idlen);
        push_word(keylen);
        for (int i = 0; i < nkey + ntrail; i++) begin
            msg_q.push_back(8'($urandom));
        end
        case (kind)
            MSG_MAGIC: begin
                cut = $urandom_range(0, 3);
                msg_q[cut] = msg_q[cut] ^ 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1)) begin
                    msg_q[POS_VERSION] = msg_q[POS_VERSION] ^ 8'($urandom_range(1, 255));
                end
            end
            MSG_VERSION: begin
                msg_q[POS_VERSION] = msg_q[POS_VERSION] ^ 8'($urandom_range(1, 255));
            end
            MSG_SHORT: begin
                cut = $urandom_range(1, HEADER_BYTES - 1);
                while (msg_q.size() > cut) void'(msg_q.pop_back());
            end
            MSG_NOISE: begin
                msg_q.delete();
                cut = $urandom_range(1, 24);
                for (int i = 0; i < cut; i++) begin
                    msg_q.push_back(8'($urandom));
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_msg_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return MSG_GOOD;
        if (r < 53) return MSG_TRUNC;
        if (r < 60) return MSG_LONG_KEY;
        if (r < 66) return MSG_MAGIC;
        if (r < 72) return MSG_VERSION;
        if (r < 78) return MSG_PERIOD;
        if (r < 84) return MSG_IDLEN;
        if (r < 90) return MSG_KEYLEN;
        if (r < 95) return MSG_SHORT;
        return MSG_NOISE;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode, input bit quiet);
        if (quiet || mode == 2) begin
            send_pct = 0;
            recv_pct = 0;
        end else if (mode == 0) begin
            send_pct = 19;
            recv_pct = 84;
        end else begin
            send_pct = 84;
            recv_pct = 19;
        end
    endtask

    initial begin
        int phase_start;
        logic        cfg_deliver;
        logic [15:0] cfg_capacity;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-byte message, sound header with extreme fields, short message
        msg_q = '{8'hFF};
        send_message();
        msg_q.delete();
        for (int i = 0; i < 4; i++) begin
            msg_q.push_back(MAGIC[i]);
        end
        msg_q.push_back(VERSION_BYTE);
        push_word(32'h7FFF_FFFF);
        push_word(MAX_ID_SYMBOLS);
        push_word(32'd1);
        msg_q.push_back(8'h00);
        send_message();
        msg_q = '{8'h00, 8'h80, 8'h7F};
        send_message();
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin cfg_deliver = 1'b1; cfg_capacity = 16'd32;    end
                1: begin cfg_deliver = 1'b1; cfg_capacity = 16'd0;     end
                2: begin cfg_deliver = 1'b0; cfg_capacity = 16'hFFFF;  end
                3: begin cfg_deliver = 1'b1; cfg_capacity = 16'hFFFF;  end
                4: begin cfg_deliver = 1'b1; cfg_capacity = 16'($urandom_range(0, 12)); end
                default: begin cfg_deliver = 1'b1; cfg_capacity = 16'd4; end
            endcase
            write_reg(REG_DELIVER_KEY, {31'd0, cfg_deliver});
            write_reg(REG_KEY_CAPACITY, {16'd0, cfg_capacity});
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                set_idling(phase / 2, $urandom_range(0, 4) == 0);
                build_message(pick_kind());
                send_message();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
